@@ rtl/rwd_pkg.sv @@
// rwd_pkg: shared types, constants and controller commands for rsa_word_decrypt
// no dependencies
`timescale 1ns / 1ps

package rwd_pkg;

	localparam int unsigned CipherW = 17;
	localparam int unsigned RegW    = 16;
	localparam int unsigned ProdW   = 2 * RegW;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [RegW-1:0] ModulusReset  = 16'd31571;
	localparam logic [RegW-1:0] ExponentReset = 16'd15031;

	localparam logic [CfgIdxW-1:0] RegModulus  = 8'd0;
	localparam logic [CfgIdxW-1:0] RegExponent = 8'd1;

	typedef struct packed {
		logic [CipherW-1:0] cipher_word;
		logic               last_word;
	} rwd_in_t;

	typedef struct packed {
		logic [ByteW-1:0] plain_byte;
		logic             last_byte;
	} rwd_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BDIV,
		ST_INIT,
		ST_SQ,
		ST_SDIV,
		ST_SQW,
		ST_MUL,
		ST_MDIV,
		ST_MW,
		ST_DONE
	} rwd_state_t;

	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_WORD,
		SEL_ZERO,
		SEL_POWER
	} rwd_sel_t;

	typedef struct packed {
		logic     capture;
		logic     load_sq;
		logic     load_mul;
		logic     step;
		logic     store_base;
		logic     store_acc;
		logic     emit;
		rwd_sel_t sel;
	} rwd_cmd_t;

endpackage

@@ rtl/rwd_datapath.sv @@
// rwd_datapath: operand registers, 16x16 multiplier and bit-serial modular reduction
// depends on rwd_pkg
`timescale 1ns / 1ps

module rwd_datapath (
	input  logic                          clk,
	input  rwd_pkg::rwd_cmd_t             cmd,
	input  rwd_pkg::rwd_in_t              cipher,
	input  logic [rwd_pkg::RegW-1:0]      modulus,
	output rwd_pkg::rwd_out_t             plain
);
	import rwd_pkg::*;

	logic [ByteW-1:0]   c_q;
	logic               last_q;
	logic [ProdW-1:0]   div_q;
	logic [RegW-1:0]    rem_q;
	logic [RegW-1:0]    acc_q;
	logic [RegW-1:0]    base_q;
	rwd_out_t           res_q;

	logic [RegW:0]      rem_ext;
	logic [RegW:0]      mod_ext;
	logic [RegW:0]      rem_sub;
	logic [RegW-1:0]    rem_next;
	logic [RegW-1:0]    acc_init;
	logic [ByteW-1:0]   byte_sel;

	always_comb begin
		rem_ext  = {rem_q, div_q[ProdW-1]};
		mod_ext  = {1'b0, modulus};
		rem_sub  = rem_ext - mod_ext;
		rem_next = (rem_ext >= mod_ext) ? rem_sub[RegW-1:0] : rem_ext[RegW-1:0];
		acc_init = (modulus == RegW'(1)) ? '0 : RegW'(1);
		case (cmd.sel)
			SEL_ONE:   byte_sel = ByteW'(1);
			SEL_WORD:  byte_sel = c_q;
			SEL_ZERO:  byte_sel = '0;
			SEL_POWER: byte_sel = acc_q[ByteW-1:0];
			default:   byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q    <= cipher.cipher_word[ByteW-1:0];
			last_q <= cipher.last_word;
			div_q  <= {{(ProdW-CipherW){1'b0}}, cipher.cipher_word};
			rem_q  <= '0;
		end else if (cmd.load_sq) begin
			div_q <= acc_q * acc_q;
			rem_q <= '0;
		end else if (cmd.load_mul) begin
			div_q <= acc_q * base_q;
			rem_q <= '0;
		end else if (cmd.step) begin
			div_q <= {div_q[ProdW-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.store_base) begin
			base_q <= rem_q;
			acc_q  <= acc_init;
		end else if (cmd.store_acc) begin
			acc_q <= rem_q;
		end
		if (cmd.emit) begin
			res_q.plain_byte <= byte_sel;
			res_q.last_byte  <= last_q;
		end
	end

	assign plain = res_q;

endmodule

@@ rtl/rwd_controller.sv @@
// rwd_controller: square-and-multiply sequencer driving the datapath
// depends on rwd_pkg
`timescale 1ns / 1ps

module rwd_controller (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rwd_pkg::RegW-1:0] modulus,
	input  logic [rwd_pkg::RegW-1:0] exponent,
	output logic                     busy,
	output rwd_pkg::rwd_cmd_t        cmd
);
	import rwd_pkg::*;

	localparam int unsigned CntW = $clog2(ProdW);
	localparam int unsigned BitW = $clog2(RegW);

	rwd_state_t      state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [BitW-1:0] bit_q, bit_d;
	rwd_sel_t        sel_q, sel_d;
	logic            cnt_last;

	assign cnt_last = (cnt_q == CntW'(ProdW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			sel_q   <= SEL_ONE;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		bit_d   = bit_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					cnt_d       = '0;
					if (exponent == '0) begin
						sel_d   = SEL_ONE;
						state_d = ST_DONE;
					end else if (exponent == RegW'(1)) begin
						sel_d   = SEL_WORD;
						state_d = ST_DONE;
					end else if (modulus == '0) begin
						sel_d   = SEL_ZERO;
						state_d = ST_DONE;
					end else begin
						sel_d   = SEL_POWER;
						state_d = ST_BDIV;
					end
				end
			end
			ST_BDIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_last) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.store_base = 1'b1;
				bit_d          = BitW'(RegW - 1);
				state_d        = ST_SQ;
			end
			ST_SQ: begin
				cmd.load_sq = 1'b1;
				cnt_d       = '0;
				state_d     = ST_SDIV;
			end
			ST_SDIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_last) state_d = ST_SQW;
			end
			ST_SQW: begin
				cmd.store_acc = 1'b1;
				if (exponent[bit_q]) begin
					state_d = ST_MUL;
				end else if (bit_q == '0) begin
					state_d = ST_DONE;
				end else begin
					bit_d   = bit_q - 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_MUL: begin
				cmd.load_mul = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MDIV;
			end
			ST_MDIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_last) state_d = ST_MW;
			end
			ST_MW: begin
				cmd.store_acc = 1'b1;
				if (bit_q == '0) begin
					state_d = ST_DONE;
				end else begin
					bit_d   = bit_q - 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/rsa_word_decrypt.sv @@
// rsa_word_decrypt: top level with configuration registers, controller and datapath
// depends on rwd_pkg, rwd_controller, rwd_datapath
// for exponent 0 or 1 or modulus 0 an accepted item goes straight to the done state; otherwise the
// base is reduced, then each of the 16 exponent bits takes a square and, if set, a multiply, each
// 16x16 product reduced in 32 steps; next item is accepted in the cycle its predecessor strobes
// reset: modulus 31571, exponent 15031, controller idle, no result pending
`timescale 1ns / 1ps

module rsa_word_decrypt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rwd_pkg::rwd_in_t            cipher,
	output logic                        done,
	output rwd_pkg::rwd_out_t           plain,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rwd_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [rwd_pkg::RegW-1:0]    cfg_data
);
	import rwd_pkg::*;

	logic [RegW-1:0] modulus_q;
	logic [RegW-1:0] exponent_q;
	logic            done_q;
	rwd_cmd_t        cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= ModulusReset;
			exponent_q <= ExponentReset;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					RegModulus:  modulus_q  <= cfg_data;
					RegExponent: exponent_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	rwd_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.modulus  (modulus_q),
		.exponent (exponent_q),
		.busy     (busy),
		.cmd      (cmd)
	);

	rwd_datapath u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.cipher  (cipher),
		.modulus (modulus_q),
		.plain   (plain)
	);

	assign done = done_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy))
		else $error("result strobe without an item in flight");

endmodule
